// ----- src/tts_pkg.sv -----
package tts_pkg;

  localparam int NUM_TILESETS = 4;
  localparam int IDX_W        = $clog2(NUM_TILESETS);
  localparam int ID_W         = 29;
  localparam int FIRST_W      = 24;
  localparam int COLS_W       = 16;
  localparam int TSZ_W        = 12;
  localparam int CELL_W       = 10;
  localparam int DEST_W       = 22;
  localparam int SRCX_W       = 28;
  localparam int SRCY_W       = 41;

  // long division: dividend padded to DVD_W, DIV_BITS quotient bits per stage
  localparam int DVD_W      = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DVD_W / DIV_BITS;

  localparam logic [31:0] FLAG_H = 32'h8000_0000;
  localparam logic [31:0] FLAG_V = 32'h4000_0000;
  localparam logic [31:0] FLAG_D = 32'h2000_0000;

  typedef enum logic [2:0] {
    CFG_TILESET_0   = 3'd0,
    CFG_TILESET_1   = 3'd1,
    CFG_TILESET_2   = 3'd2,
    CFG_TILESET_3   = 3'd3,
    CFG_TS_COUNT    = 3'd4,
    CFG_MAP_TILE_W  = 3'd5,
    CFG_MAP_TILE_H  = 3'd6
  } cfg_idx_t;

  // one tileset register, bits 63:0
  typedef struct packed {
    logic [TSZ_W-1:0]   th;
    logic [TSZ_W-1:0]   tw;
    logic [COLS_W-1:0]  cols;
    logic [FIRST_W-1:0] first;
  } tileset_t;

  typedef struct packed {
    logic [31:0]       tile_word;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  tileset_index;
    logic [SRCX_W-1:0] src_x;
    logic [SRCY_W-1:0] src_y;
    logic [TSZ_W-1:0]  src_w;
    logic [TSZ_W-1:0]  src_h;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic              mirror_h;
    logic              mirror_v;
  } out_item_t;

  // payload carried through the divider stages
  typedef struct packed {
    logic [DVD_W-1:0]  dvd;
    logic [COLS_W-1:0] rem;
    logic [DVD_W-1:0]  quo;
    logic [COLS_W-1:0] cols;
    logic [TSZ_W-1:0]  tw;
    logic [TSZ_W-1:0]  th;
    logic [IDX_W-1:0]  idx;
    logic              mh;
    logic              mv;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
  } pipe_t;

endpackage

// ----- src/tile_to_sprite_rect.sv -----
// tile_to_sprite_rect: turns one raw tile word plus its map cell into a sprite
// draw request (tileset index, source rectangle, destination, mirror flags).
// A transaction is taken on every clock edge with start high; busy is tied low,
// so the block takes one tile per cycle, back to back, with no gaps. The result
// of a transaction appears on out_data with out_valid high for exactly one
// cycle, in input order. The receiver cannot stall the block, so it must
// sample every out_valid cycle. A zero tile word, or a tile id below every
// tileset in use, produces no result at all: the slot just stays empty. Each
// tile passes through the pipeline: one input register, one tileset select
// stage, eight divide stages (four quotient bits each, for column = local
// id mod columns and row = local id div columns), and one multiply stage
// feeding the output register. Configuration registers are
// written through cfg_we/cfg_index/cfg_data with no wait; write them only
// while no transaction is in flight. A column count of zero divides as one, a
// tileset count above four acts as four, and writes to index 7 are dropped.
module tile_to_sprite_rect
  import tts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  // command channel
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_data,
  // result channel
  output logic            out_valid,
  output out_item_t       out_data,
  // configuration
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  tileset_t          tileset_r [NUM_TILESETS];
  logic [2:0]        count_r;
  logic [TSZ_W-1:0]  map_w_r;
  logic [TSZ_W-1:0]  map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TILESETS; i++) begin
        tileset_r[i] <= '0;
      end
      count_r <= '0;
      map_w_r <= '0;
      map_h_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TILESET_0:  tileset_r[0] <= tileset_t'(cfg_data);
        CFG_TILESET_1:  tileset_r[1] <= tileset_t'(cfg_data);
        CFG_TILESET_2:  tileset_r[2] <= tileset_t'(cfg_data);
        CFG_TILESET_3:  tileset_r[3] <= tileset_t'(cfg_data);
        CFG_TS_COUNT:   count_r      <= cfg_data[2:0];
        CFG_MAP_TILE_W: map_w_r      <= cfg_data[TSZ_W-1:0];
        CFG_MAP_TILE_H: map_h_r      <= cfg_data[TSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 0: input register; zero words are dropped here
  // ---------------------------------------------------------------------------
  logic     in_vld_r;
  in_item_t in_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy && (in_data.tile_word != '0);
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_data;
  end

  // ---------------------------------------------------------------------------
  // stage 1: tileset select, local id, destination multiply
  // ---------------------------------------------------------------------------
  logic              sel_vld_r;
  logic              sel_vld_nxt;
  pipe_t             sel_r;
  pipe_t             sel_nxt;
  logic [2:0]        used;
  logic [ID_W-1:0]   tile_id;
  tileset_t          ts_pick;
  logic [ID_W-1:0]   loc_id;

  always_comb begin
    used    = (count_r > 3'(NUM_TILESETS)) ? 3'(NUM_TILESETS) : count_r;
    tile_id = in_item_r.tile_word[ID_W-1:0];
    ts_pick = '0;
    sel_vld_nxt = 1'b0;
    sel_nxt = '0;
    // ascending scan: the highest matching entry wins
    for (int i = 0; i < NUM_TILESETS; i++) begin
      if ((3'(i) < used) && (ID_W'(tileset_r[i].first) <= tile_id)) begin
        sel_vld_nxt = in_vld_r;
        sel_nxt.idx = IDX_W'(i);
        ts_pick     = tileset_r[i];
      end
    end
    loc_id        = tile_id - ID_W'(ts_pick.first);
    sel_nxt.dvd   = DVD_W'(loc_id);
    sel_nxt.rem   = '0;
    sel_nxt.quo   = '0;
    sel_nxt.cols  = (ts_pick.cols == '0) ? COLS_W'(1) : ts_pick.cols;
    sel_nxt.tw    = ts_pick.tw;
    sel_nxt.th    = ts_pick.th;
    sel_nxt.mh    = (in_item_r.tile_word & (FLAG_H | FLAG_D)) != '0;
    sel_nxt.mv    = (in_item_r.tile_word & (FLAG_V | FLAG_D)) != '0;
    sel_nxt.dest_x = DEST_W'(in_item_r.cell_x) * DEST_W'(map_w_r);
    sel_nxt.dest_y = DEST_W'(in_item_r.cell_y) * DEST_W'(map_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= sel_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  // ---------------------------------------------------------------------------
  // stages 2..9: restoring division, DIV_BITS quotient bits per stage
  // ---------------------------------------------------------------------------
  logic  div_vld_r [DIV_STAGES];
  pipe_t div_r     [DIV_STAGES];
  pipe_t div_nxt   [DIV_STAGES];

  always_comb begin
    pipe_t          cur;
    logic [COLS_W:0] trial;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = (k == 0) ? sel_r : div_r[(k == 0) ? 0 : k-1];
      for (int b = 0; b < DIV_BITS; b++) begin
        trial   = {cur.rem, cur.dvd[DVD_W-1]};
        cur.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, cur.cols}) begin
          trial   = trial - {1'b0, cur.cols};
          cur.quo = {cur.quo[DVD_W-2:0], 1'b1};
        end else begin
          cur.quo = {cur.quo[DVD_W-2:0], 1'b0};
        end
        cur.rem = trial[COLS_W-1:0];
      end
      div_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_vld_r[k] <= 1'b0;
      end
    end else begin
      div_vld_r[0] <= sel_vld_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_vld_r[k] <= div_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      div_r[k] <= div_nxt[k];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: scale column/row by tile size into the output register
  // ---------------------------------------------------------------------------
  pipe_t     last;
  logic      out_vld_r;
  out_item_t out_r;
  out_item_t out_nxt;

  always_comb begin
    last                  = div_r[DIV_STAGES-1];
    out_nxt.tileset_index = last.idx;
    out_nxt.src_x         = SRCX_W'(last.rem) * SRCX_W'(last.tw);
    out_nxt.src_y         = SRCY_W'(last.quo[ID_W-1:0]) * SRCY_W'(last.th);
    out_nxt.src_w         = last.tw;
    out_nxt.src_h         = last.th;
    out_nxt.dest_x        = last.dest_x;
    out_nxt.dest_y        = last.dest_y;
    out_nxt.mirror_h      = last.mh;
    out_nxt.mirror_v      = last.mv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= div_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // remainder leaving the divider is a true column
  a_rem_lt_cols: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[DIV_STAGES-1] |-> (div_r[DIV_STAGES-1].rem < div_r[DIV_STAGES-1].cols))
    else $error("divider remainder not below column count");

  // selected tileset is always one in use
  a_idx_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    sel_vld_r |-> ({1'b0, sel_r.idx} < count_r))
    else $error("selected tileset beyond tileset_count");

  // a result strobe needs a valid item in the last divide stage
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(div_vld_r[DIV_STAGES-1]))
    else $error("result strobe without a transaction behind it");

  // divider never sees a zero divisor
  a_cols_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sel_vld_r |-> (sel_r.cols != '0))
    else $error("zero column count reached the divider");

endmodule
